// File: hdl/lrt_pkg.sv
// Shared types and constants of the register cache tracker.
`timescale 1ns / 1ps
`default_nettype none

package lrt_pkg;

  // Field widths fixed by the transaction format.
  localparam int unsigned TagW = 10;
  localparam int unsigned CapW = 6;

  // Operation codes of an input transaction.
  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_MARK   = 1'b1
  } op_e;

  // Request presented to the tag store for one transaction.
  typedef struct packed {
    logic            valid;
    op_e             op;
    logic [TagW-1:0] tag;
  } store_req_t;

  // Response of the tag store for the same transaction.
  typedef struct packed {
    logic            hit;
    logic            evicted_valid;
    logic [TagW-1:0] evicted_index;
  } store_rsp_t;

endpackage

`default_nettype wire

// File: hdl/lrt_stream_if.sv
// Valid/ready stream interfaces for the tracker's input and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface lrt_in_if
  import lrt_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [0:0]      operation;
  logic [TagW-1:0] reg_index;

  modport source (output valid, output operation, output reg_index, input ready);
  modport sink   (input valid, input operation, input reg_index, output ready);
endinterface

interface lrt_out_if
  import lrt_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [0:0]      hit;
  logic [0:0]      evicted_valid;
  logic [TagW-1:0] evicted_index;

  modport source (output valid, output hit, output evicted_valid, output evicted_index,
                  input ready);
  modport sink   (input valid, input hit, input evicted_valid, input evicted_index,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/lru_register_cache_tracker.sv
// Top level of the LRU register cache tracker: input stage, tag store, result stage.
//
// Usage:
//   in_i carries one transaction per register access: operation (lookup or
//   mark) and reg_index. out_o returns exactly one result per transaction, in
//   order: hit, evicted_valid and evicted_index.
//   cfg_we_i with cfg_wdata_i writes the capacity register; a write empties
//   the store. Capacity zero disables tracking; values above MAX_ENTRIES act
//   as MAX_ENTRIES. Write it only while no transaction is in flight.
// Pipeline and throughput:
//   A transaction is captured in the input register, then the tag store
//   matches, ranks and updates combinationally while the result register loads.
//   The result is held in the result register until out_o takes it.
//   One transaction per cycle is sustained while out_o is ready; the
//   rate is set by the combinational CAM and rank update of the tag store.
// Reset and stalls:
//   rst_ni clears the store, the capacity (to zero) and both stages. When
//   out_o stalls, the result register holds and the input register can still
//   take one more transaction before in_i.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module lru_register_cache_tracker
  import lrt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CapW-1:0] cfg_wdata_i,
  lrt_in_if.sink               in_i,
  lrt_out_if.source            out_o
);

  localparam int unsigned OccW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW = (OccW > CapW) ? OccW : CapW;

  logic [CapW-1:0] cap_q;
  logic [OccW-1:0] cap_eff;
  logic [CmpW-1:0] cap_ext;
  logic [CmpW-1:0] max_ext;

  logic            in_valid_q;
  op_e             op_q;
  logic [TagW-1:0] tag_q;
  logic            res_valid_q, res_valid_d;
  store_rsp_t      res_q;
  logic            advance;
  store_req_t      req;
  store_rsp_t      rsp;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Saturate the capacity to the number of entries.
  always_comb begin
    cap_ext = CmpW'(cap_q);
    max_ext = CmpW'(MAX_ENTRIES);
    cap_eff = OccW'((cap_ext > max_ext) ? max_ext : cap_ext);
  end

  // Pipeline control: the held transaction moves on when the result slot frees.
  assign advance     = in_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign res_valid_d = advance || (res_valid_q && !out_o.ready);

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q  <= op_e'(in_i.operation);
      tag_q <= in_i.reg_index;
    end
  end

  // Tag store request for the transaction leaving the input stage.
  always_comb begin
    req.valid = advance;
    req.op    = op_q;
    req.tag   = tag_q;
  end

  lrt_tag_store #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(cfg_we_i),
    .cap_i  (cap_eff),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= rsp;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.hit           = res_q.hit;
  assign out_o.evicted_valid = res_q.evicted_valid;
  assign out_o.evicted_index = res_q.evicted_index;

endmodule

`default_nettype wire

// File: hdl/lrt_tag_store.sv
// Fully associative tag store with per-entry age ranks and a registered, combinationally computed update.
`timescale 1ns / 1ps
`default_nettype none

module lrt_tag_store
  import lrt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               clear_i,
  input  wire logic [$clog2(MAX_ENTRIES+1)-1:0]   cap_i,
  input  wire store_req_t                         req_i,
  output      store_rsp_t                         rsp_o
);

  localparam int unsigned RankW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned OccW  = $clog2(MAX_ENTRIES + 1);

  logic [TagW-1:0]  tag_q   [MAX_ENTRIES];
  logic [TagW-1:0]  tag_d   [MAX_ENTRIES];
  logic [RankW-1:0] rank_q  [MAX_ENTRIES];
  logic [RankW-1:0] rank_d  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [OccW-1:0]  occ_q, occ_d;

  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] victim;
  logic                   hit;
  logic [RankW-1:0]       hit_rank;
  logic                   free_found;
  logic [RankW-1:0]       free_idx;
  logic                   full;
  logic [OccW-1:0]        oldest;
  logic [TagW-1:0]        victim_tag;
  logic                   do_mark;

  // Associative match, free slot search and victim selection.
  always_comb begin
    hit_rank   = '0;
    victim_tag = '0;
    free_found = 1'b0;
    free_idx   = '0;
    oldest     = occ_q - OccW'(1);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i]  = valid_q[i] && (tag_q[i] == req_i.tag);
      victim[i] = valid_q[i] && (OccW'(rank_q[i]) == oldest);
      if (match[i]) begin
        hit_rank = hit_rank | rank_q[i];
      end
      if (victim[i]) begin
        victim_tag = victim_tag | tag_q[i];
      end
    end
    // Scan downward so the lowest free slot wins.
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = RankW'(i);
      end
    end
    hit     = |match;
    full    = (occ_q >= cap_i);
    do_mark = req_i.valid && (req_i.op == OP_MARK) && (cap_i != '0);
  end

  // Next state of every entry for a mark transaction.
  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      tag_d[i]  = tag_q[i];
      rank_d[i] = rank_q[i];
    end
    if (do_mark) begin
      if (hit) begin
        // Promote the matching entry; younger entries age by one.
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (match[i]) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
            rank_d[i] = rank_q[i] + RankW'(1);
          end
        end
      end else if (!full && free_found) begin
        // Insert into the first free slot; every valid entry ages.
        occ_d = occ_q + OccW'(1);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + RankW'(1);
          end
        end
        valid_d[free_idx] = 1'b1;
        tag_d[free_idx]   = req_i.tag;
        rank_d[free_idx]  = '0;
      end else if (full) begin
        // Replace the oldest entry; the rest age by one.
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (victim[i]) begin
            tag_d[i]  = req_i.tag;
            rank_d[i] = '0;
          end else if (valid_q[i] && (OccW'(rank_q[i]) < oldest)) begin
            rank_d[i] = rank_q[i] + RankW'(1);
          end
        end
      end
    end
  end

  // Control state and ranks, cleared on reset and on a capacity write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (clear_i) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Tags hold payload only and need no reset.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      tag_q[i] <= tag_d[i];
    end
  end

  // Response of the current transaction.
  always_comb begin
    rsp_o.hit           = hit;
    rsp_o.evicted_valid = do_mark && !hit && full;
    rsp_o.evicted_index = (do_mark && !hit && full) ? victim_tag : '0;
  end

  // Occupancy always equals the number of valid entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy does not match the valid entries");

  // A tag is held by at most one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(match))
    else $error("tag matches more than one entry");

  // An eviction happens only with the store full, and it picks exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.evicted_valid |-> (occ_q == cap_i) && $onehot(victim))
    else $error("eviction without a full store or a unique victim");

  // A capacity write leaves the store empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> (occ_q == '0) && (valid_q == '0))
    else $error("store not empty after clear");

endmodule

`default_nettype wire
